/* src/cpss_pkg.sv */
// shared types, constants and prefix helper functions for the cidr prefix set block
`timescale 1ns / 1ps
package cpss_pkg;

   // address space and limits
   localparam int unsigned PFX_MAX         = 128;
   localparam int unsigned V4_BASE         = 96;
   localparam int unsigned V4_BITS         = 32;
   localparam int unsigned RESULT_LIMIT    = 32;
   localparam int unsigned TABLE_DEPTH_DEF = 32;

   // port widths
   localparam int unsigned DATA_BITS     = 136;
   localparam int unsigned IN_USER_BITS  = 3;
   localparam int unsigned OUT_USER_BITS = 4;

   typedef logic [PFX_MAX-1:0] net_type;
   typedef logic [7:0]         len_type;

   typedef struct packed {
      net_type net;
      len_type len;
   } entry_type;

   typedef enum logic [1:0] {
      OP_INCLUDE  = 2'd0,
      OP_EXCLUDE  = 2'd1,
      OP_FINISH   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FAMILY   = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_BAD_V4   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FAM_NONE = 2'd0,
      FAM_V4   = 2'd1,
      FAM_V6   = 2'd2
   } fam_type;

   // source of a table write
   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_ENTRY = 2'd1,
      WR_ITEM  = 2'd2,
      WR_PIECE = 2'd3
   } wr_type;

   // kind of result loaded into the output register
   typedef enum logic [1:0] {
      OUT_NONE   = 2'd0,
      OUT_RESULT = 2'd1,
      OUT_ENTRY  = 2'd2,
      OUT_EMPTY  = 2'd3
   } out_type;

   // controller to datapath
   typedef struct packed {
      logic    load_item;
      logic    decide;
      logic    clr_scan;
      logic    scan_acc;
      logic    clr_ridx;
      logic    inc_ridx;
      logic    clr_wcnt;
      logic    lvl_from_xlen;
      logic    lvl_from_entry;
      logic    lvl_inc;
      logic    lvl_dec;
      logic    shrink;
      logic    set_ins;
      logic    commit;
      logic    fin_clear;
      wr_type  wr_sel;
      out_type out_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   bad_v4;
      logic   fam_bad;
      logic   scan_end;
      logic   hit;
      logic   cover_x_e;
      logic   cover_e_x;
      logic   ins;
      logic   x_before_e;
      logic   sib_at_lvl;
      logic   lvl_above_xlen;
      logic   lvl_at_base;
      logic   xbit_at_lvl;
      logic   out_free;
      logic   fin_last;
      logic   cnt_zero;
   } stat_type;

   // network mask of a prefix length, all ones from 128 up
   function automatic net_type pfx_mask(input len_type len);
      return ~(net_type'('1) >> len);
   endfunction

   // single bit at prefix position len (1 is the top bit), zero for len 0
   function automatic net_type bit_mask(input len_type len);
      return net_type'(1) << (len_type'(PFX_MAX) - len);
   endfunction

   function automatic logic covers(input entry_type a, input entry_type b);
      return (a.len <= b.len) && ((b.net & pfx_mask(a.len)) == a.net);
   endfunction

   // e is the sibling of the ancestor of x at e's length
   function automatic logic path_sibling(input entry_type x, input entry_type e);
      return (e.len != '0) && (e.len <= x.len) &&
             (((x.net & pfx_mask(e.len)) ^ bit_mask(e.len)) == e.net);
   endfunction

   function automatic logic bit_at(input net_type net, input len_type len);
      return |(net & bit_mask(len));
   endfunction

   // sort order: network, then length
   function automatic logic sorts_before(input entry_type a, input entry_type b);
      return {a.net, a.len} < {b.net, b.len};
   endfunction

   // split piece off the path to x at length len
   function automatic entry_type piece(input entry_type x, input len_type len);
      entry_type p;
      p.net = (x.net & pfx_mask(len)) ^ bit_mask(len);
      p.len = len;
      return p;
   endfunction

endpackage

/* src/cidr_prefix_set_subtract_top.sv */
// top level of the cidr prefix set block: controller plus datapath
`timescale 1ns / 1ps
// Keeps a canonical set of 128-bit prefixes (ipv4 in the low 32 bits).
// Request channel req_*: one transaction per operation, include, exclude
// or finish. Response channel rsp_*: one result per include or exclude,
// one per table entry (at most 32, tlast on the final one) on finish.
// Transactions are taken one at a time; req_tready is high while the
// sequencer is idle, also when a result still waits in the output register.
// Each pass over the table reads the table ram, which has registered read,
// entry by entry. An include scans for a covering entry and for siblings
// on the path, climbs the merge levels and rewrites the table with the
// merged prefix in order; when an entry already covers the item it goes
// straight to the result after the scan. An exclude rewrites the table,
// dropping covered entries and splitting a covering entry level by level.
// A rejected item goes straight to the result; finish streams the entries.
// The sequencer returns to idle after each item.
// Reset empties the table and forgets family and overflow.
// While rsp_tready is low, a loaded result holds and the sequencer waits
// before loading the next one; nothing is dropped.
module cidr_prefix_set_subtract_top #(
   parameter int unsigned TABLE_DEPTH = cpss_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // network_high, network_low, prefix_bits, 136 bits in all
   input  logic [cpss_pkg::DATA_BITS-1:0]       req_tdata,
   // operation, family_v6
   input  logic [cpss_pkg::IN_USER_BITS-1:0]    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_network_high, out_network_low, out_prefix_bits
   output logic [cpss_pkg::DATA_BITS-1:0]       rsp_tdata,
   // out_family_v6, table_empty, status
   output logic [cpss_pkg::OUT_USER_BITS-1:0]   rsp_tuser,
   output logic                                 rsp_tlast
);

   cpss_pkg::cmd_type  cmd;
   cpss_pkg::stat_type stat;

   // sequencer
   cpss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // tables and arithmetic
   cpss_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/cpss_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cpss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/cpss_ctrl.sv */
// sequencing state machine for include, exclude and finish transactions
`timescale 1ns / 1ps
module cpss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  cpss_pkg::stat_type stat,
   output cpss_pkg::cmd_type  cmd
);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_DECODE   = 14'b00000000000010,
      S_RESULT   = 14'b00000000000100,
      S_INC_RD   = 14'b00000000001000,
      S_INC_USE  = 14'b00000000010000,
      S_WALK     = 14'b00000000100000,
      S_INSW_RD  = 14'b00000001000000,
      S_INSW_USE = 14'b00000010000000,
      S_EXC_RD   = 14'b00000100000000,
      S_EXC_USE  = 14'b00001000000000,
      S_EXC_LO   = 14'b00010000000000,
      S_EXC_HI   = 14'b00100000000000,
      S_FIN_RD   = 14'b01000000000000,
      S_FIN_USE  = 14'b10000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               cpss_pkg::OP_RESERVED: begin
                  state_in = S_IDLE;
               end
               cpss_pkg::OP_FINISH: begin
                  cmd.clr_ridx = 1'b1;
                  state_in     = S_FIN_RD;
               end
               cpss_pkg::OP_INCLUDE, cpss_pkg::OP_EXCLUDE: begin
                  cmd.decide   = 1'b1;
                  cmd.clr_ridx = 1'b1;
                  cmd.clr_scan = 1'b1;
                  cmd.clr_wcnt = 1'b1;
                  priority if (stat.bad_v4 || stat.fam_bad) begin
                     state_in = S_RESULT;
                  end else if (stat.op == cpss_pkg::OP_INCLUDE) begin
                     state_in = S_INC_RD;
                  end else begin
                     state_in = S_EXC_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.out_sel = cpss_pkg::OUT_RESULT;
               state_in    = S_IDLE;
            end
         end
         // include: look for a covering entry and siblings on the path
         S_INC_RD: begin
            priority if (!stat.scan_end) begin
               state_in = S_INC_USE;
            end else if (stat.hit) begin
               state_in = S_RESULT;
            end else begin
               cmd.lvl_from_xlen = 1'b1;
               state_in          = S_WALK;
            end
         end
         S_INC_USE: begin
            cmd.scan_acc = 1'b1;
            cmd.inc_ridx = 1'b1;
            state_in     = S_INC_RD;
         end
         // climb while the sibling at this level is present
         S_WALK: begin
            if (stat.sib_at_lvl) begin
               cmd.lvl_dec = 1'b1;
            end else begin
               cmd.shrink   = 1'b1;
               cmd.clr_ridx = 1'b1;
               state_in     = S_INSW_RD;
            end
         end
         // include: rewrite table with the merged prefix in order
         S_INSW_RD: begin
            if (stat.scan_end) begin
               if (!stat.ins) begin
                  cmd.wr_sel = cpss_pkg::WR_ITEM;
               end
               cmd.commit = 1'b1;
               state_in   = S_RESULT;
            end else begin
               state_in = S_INSW_USE;
            end
         end
         S_INSW_USE: begin
            priority if (stat.cover_x_e) begin
               cmd.inc_ridx = 1'b1;
               state_in     = S_INSW_RD;
            end else if (!stat.ins && stat.x_before_e) begin
               cmd.wr_sel  = cpss_pkg::WR_ITEM;
               cmd.set_ins = 1'b1;
            end else begin
               cmd.wr_sel   = cpss_pkg::WR_ENTRY;
               cmd.inc_ridx = 1'b1;
               state_in     = S_INSW_RD;
            end
         end
         // exclude: drop covered entries, split the covering one
         S_EXC_RD: begin
            if (stat.scan_end) begin
               cmd.commit = 1'b1;
               state_in   = S_RESULT;
            end else begin
               state_in = S_EXC_USE;
            end
         end
         S_EXC_USE: begin
            cmd.inc_ridx = 1'b1;
            priority if (stat.cover_x_e) begin
               state_in = S_EXC_RD;
            end else if (stat.cover_e_x) begin
               cmd.lvl_from_entry = 1'b1;
               state_in           = S_EXC_LO;
            end else begin
               cmd.wr_sel = cpss_pkg::WR_ENTRY;
               state_in   = S_EXC_RD;
            end
         end
         // pieces below the excluded range, shortest first
         S_EXC_LO: begin
            if (stat.lvl_above_xlen) begin
               cmd.lvl_from_xlen = 1'b1;
               state_in          = S_EXC_HI;
            end else begin
               if (stat.xbit_at_lvl) begin
                  cmd.wr_sel = cpss_pkg::WR_PIECE;
               end
               cmd.lvl_inc = 1'b1;
            end
         end
         // pieces above the excluded range, longest first
         S_EXC_HI: begin
            if (stat.lvl_at_base) begin
               state_in = S_EXC_RD;
            end else begin
               if (!stat.xbit_at_lvl) begin
                  cmd.wr_sel = cpss_pkg::WR_PIECE;
               end
               cmd.lvl_dec = 1'b1;
            end
         end
         // finish: stream the sorted table out
         S_FIN_RD: begin
            if (stat.cnt_zero) begin
               if (stat.out_free) begin
                  cmd.out_sel   = cpss_pkg::OUT_EMPTY;
                  cmd.fin_clear = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_FIN_USE;
            end
         end
         S_FIN_USE: begin
            if (stat.out_free) begin
               cmd.out_sel  = cpss_pkg::OUT_ENTRY;
               cmd.inc_ridx = 1'b1;
               if (stat.fin_last) begin
                  cmd.fin_clear = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_FIN_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/cpss_datapath.sv */
// item register, ping-pong prefix tables, counters and output register
`timescale 1ns / 1ps
module cpss_datapath #(
   parameter int unsigned TABLE_DEPTH = cpss_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cpss_pkg::cmd_type                    cmd,
   output cpss_pkg::stat_type                   stat,
   input  logic [cpss_pkg::DATA_BITS-1:0]       req_tdata,
   input  logic [cpss_pkg::IN_USER_BITS-1:0]    req_tuser,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [cpss_pkg::DATA_BITS-1:0]       rsp_tdata,
   output logic [cpss_pkg::OUT_USER_BITS-1:0]   rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned EW = $bits(cpss_pkg::entry_type);

   // item and run state
   cpss_pkg::entry_type  x_ff, x_in;
   cpss_pkg::op_type     op_ff, op_in;
   logic                 v6_ff, v6_in;
   logic                 bad_v4_ff, bad_v4_in;
   cpss_pkg::status_type status_ff, status_in;
   cpss_pkg::fam_type    fam_ff, fam_in;
   logic                 ovf_ff, ovf_in;
   // table walking
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        wcnt_ff, wcnt_in;
   logic [CW-1:0]        ridx_ff, ridx_in;
   logic                 bank_ff, bank_in;
   logic                 hit_ff, hit_in;
   logic                 ins_ff, ins_in;
   logic [cpss_pkg::PFX_MAX:0] sib_ff, sib_in;
   cpss_pkg::len_type    lvl_ff, lvl_in;
   cpss_pkg::len_type    base_ff, base_in;
   // output register
   logic                 out_valid_ff, out_valid_in;
   cpss_pkg::entry_type  out_entry_ff, out_entry_in;
   logic                 out_v6_ff, out_v6_in;
   logic                 out_empty_ff, out_empty_in;
   cpss_pkg::status_type out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   // input decode
   cpss_pkg::len_type    raw_len;
   cpss_pkg::len_type    clamp_len;
   cpss_pkg::net_type    raw_net;
   logic                 raw_v6;
   cpss_pkg::fam_type    item_fam;
   logic                 fam_bad;

   // table ports
   logic [EW-1:0]        rdata_a, rdata_b;
   cpss_pkg::entry_type  rd_entry;
   cpss_pkg::entry_type  wr_entry;
   logic                 wr_req, wr_en;
   cpss_pkg::status_type run_status;
   logic                 fin_last;

   assign raw_len   = req_tdata[135:128];
   assign raw_v6    = req_tuser[2];
   assign clamp_len = (raw_len > cpss_pkg::len_type'(cpss_pkg::PFX_MAX)) ?
                      cpss_pkg::len_type'(cpss_pkg::PFX_MAX) : raw_len;
   // ipv4 lives in the low 32 bits, upper bits forced clear
   assign raw_net   = raw_v6 ? {req_tdata[63:0], req_tdata[127:64]} :
                      {{(cpss_pkg::PFX_MAX - cpss_pkg::V4_BITS){1'b0}},
                       req_tdata[64 +: cpss_pkg::V4_BITS]};

   assign item_fam = v6_ff ? cpss_pkg::FAM_V6 : cpss_pkg::FAM_V4;
   assign fam_bad  = (fam_ff != cpss_pkg::FAM_NONE) && (fam_ff != item_fam);

   assign rd_entry   = cpss_pkg::entry_type'(bank_ff ? rdata_b : rdata_a);
   assign run_status = ovf_ff ? cpss_pkg::ST_OVERFLOW : cpss_pkg::ST_OK;
   assign fin_last   = ((ridx_ff + 1'b1) == cnt_ff) ||
                       (32'(ridx_ff) == cpss_pkg::RESULT_LIMIT - 1);

   // write source selection
   always_comb begin
      unique case (cmd.wr_sel)
         cpss_pkg::WR_ENTRY: wr_entry = rd_entry;
         cpss_pkg::WR_ITEM:  wr_entry = x_ff;
         cpss_pkg::WR_PIECE: wr_entry = cpss_pkg::piece(x_ff, lvl_ff);
         default:            wr_entry = x_ff;
      endcase
   end

   assign wr_req = (cmd.wr_sel != cpss_pkg::WR_NONE);
   assign wr_en  = wr_req && (wcnt_ff < CW'(TABLE_DEPTH));

   // ping-pong tables: read the current bank, write the other
   cpss_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table_a (
      .clock (clock),
      .we    (wr_en && bank_ff),
      .waddr (wcnt_ff[AW-1:0]),
      .wdata (wr_entry),
      .raddr (ridx_ff[AW-1:0]),
      .rdata (rdata_a)
   );

   cpss_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table_b (
      .clock (clock),
      .we    (wr_en && !bank_ff),
      .waddr (wcnt_ff[AW-1:0]),
      .wdata (wr_entry),
      .raddr (ridx_ff[AW-1:0]),
      .rdata (rdata_b)
   );

   // next state of all registers
   always_comb begin
      x_in          = x_ff;
      op_in         = op_ff;
      v6_in         = v6_ff;
      bad_v4_in     = bad_v4_ff;
      status_in     = status_ff;
      fam_in        = fam_ff;
      ovf_in        = ovf_ff;
      cnt_in        = cnt_ff;
      wcnt_in       = wcnt_ff;
      ridx_in       = ridx_ff;
      bank_in       = bank_ff;
      hit_in        = hit_ff;
      ins_in        = ins_ff;
      sib_in        = sib_ff;
      lvl_in        = lvl_ff;
      base_in       = base_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_entry_in  = out_entry_ff;
      out_v6_in     = out_v6_ff;
      out_empty_in  = out_empty_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      // capture and mask the accepted transaction
      if (cmd.load_item) begin
         x_in.net  = raw_net & cpss_pkg::pfx_mask(clamp_len);
         x_in.len  = clamp_len;
         op_in     = cpss_pkg::op_type'(req_tuser[1:0]);
         v6_in     = raw_v6;
         bad_v4_in = !raw_v6 && (clamp_len < cpss_pkg::len_type'(cpss_pkg::V4_BASE));
         status_in = cpss_pkg::ST_OK;
      end

      // status checks and family choice
      if (cmd.decide) begin
         priority if (bad_v4_ff) begin
            status_in = cpss_pkg::ST_BAD_V4;
         end else if (fam_bad) begin
            status_in = cpss_pkg::ST_FAMILY;
         end else begin
            fam_in = item_fam;
         end
      end

      if (cmd.clr_scan) begin
         hit_in = 1'b0;
         ins_in = 1'b0;
         sib_in = '0;
      end
      if (cmd.scan_acc) begin
         if (cpss_pkg::covers(rd_entry, x_ff)) begin
            hit_in = 1'b1;
         end
         if (cpss_pkg::path_sibling(x_ff, rd_entry)) begin
            sib_in[rd_entry.len] = 1'b1;
         end
      end
      if (cmd.set_ins) begin
         ins_in = 1'b1;
      end

      if (cmd.clr_ridx) begin
         ridx_in = '0;
      end
      if (cmd.inc_ridx) begin
         ridx_in = ridx_ff + 1'b1;
      end

      // level counter for the merge climb and the split pieces
      if (cmd.lvl_from_xlen) begin
         lvl_in = x_ff.len;
      end
      if (cmd.lvl_from_entry) begin
         base_in = rd_entry.len;
         lvl_in  = rd_entry.len + 1'b1;
      end
      if (cmd.lvl_inc) begin
         lvl_in = lvl_ff + 1'b1;
      end
      if (cmd.lvl_dec) begin
         lvl_in = lvl_ff - 1'b1;
      end
      if (cmd.shrink) begin
         x_in.net = x_ff.net & cpss_pkg::pfx_mask(lvl_ff);
         x_in.len = lvl_ff;
      end

      // new table fill, entries beyond the depth are lost
      if (cmd.clr_wcnt) begin
         wcnt_in = '0;
      end
      if (wr_en) begin
         wcnt_in = wcnt_ff + 1'b1;
      end else if (wr_req) begin
         ovf_in = 1'b1;
      end
      if (cmd.commit) begin
         bank_in = !bank_ff;
         cnt_in  = wcnt_in;
      end

      // output register load
      unique case (cmd.out_sel)
         cpss_pkg::OUT_RESULT: begin
            out_valid_in  = 1'b1;
            out_entry_in  = '0;
            out_v6_in     = (fam_ff == cpss_pkg::FAM_V6);
            out_empty_in  = (cnt_ff == '0);
            out_status_in = (status_ff != cpss_pkg::ST_OK) ? status_ff : run_status;
            out_last_in   = 1'b1;
         end
         cpss_pkg::OUT_ENTRY: begin
            out_valid_in  = 1'b1;
            out_entry_in  = rd_entry;
            out_v6_in     = (fam_ff == cpss_pkg::FAM_V6);
            out_empty_in  = 1'b0;
            out_status_in = run_status;
            out_last_in   = fin_last;
         end
         cpss_pkg::OUT_EMPTY: begin
            out_valid_in  = 1'b1;
            out_entry_in  = '0;
            out_v6_in     = (fam_ff == cpss_pkg::FAM_V6);
            out_empty_in  = 1'b1;
            out_status_in = run_status;
            out_last_in   = 1'b1;
         end
         default: begin
         end
      endcase

      // end of a run
      if (cmd.fin_clear) begin
         cnt_in = '0;
         fam_in = cpss_pkg::FAM_NONE;
         ovf_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fam_ff       <= cpss_pkg::FAM_NONE;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         wcnt_ff      <= '0;
         ridx_ff      <= '0;
         bank_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fam_ff       <= fam_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         wcnt_ff      <= wcnt_in;
         ridx_ff      <= ridx_in;
         bank_ff      <= bank_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      op_ff         <= op_in;
      v6_ff         <= v6_in;
      bad_v4_ff     <= bad_v4_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      ins_ff        <= ins_in;
      sib_ff        <= sib_in;
      lvl_ff        <= lvl_in;
      base_ff       <= base_in;
      out_entry_ff  <= out_entry_in;
      out_v6_ff     <= out_v6_in;
      out_empty_ff  <= out_empty_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // status to the controller
   assign stat.op             = op_ff;
   assign stat.bad_v4         = bad_v4_ff;
   assign stat.fam_bad        = fam_bad;
   assign stat.scan_end       = (ridx_ff == cnt_ff);
   assign stat.hit            = hit_ff;
   assign stat.cover_x_e      = cpss_pkg::covers(x_ff, rd_entry);
   assign stat.cover_e_x      = cpss_pkg::covers(rd_entry, x_ff);
   assign stat.ins            = ins_ff;
   assign stat.x_before_e     = cpss_pkg::sorts_before(x_ff, rd_entry);
   assign stat.sib_at_lvl     = (lvl_ff != '0) && sib_ff[lvl_ff];
   assign stat.lvl_above_xlen = (lvl_ff > x_ff.len);
   assign stat.lvl_at_base    = (lvl_ff <= base_ff);
   assign stat.xbit_at_lvl    = cpss_pkg::bit_at(x_ff.net, lvl_ff);
   assign stat.out_free       = !out_valid_ff || rsp_tready;
   assign stat.fin_last       = fin_last;
   assign stat.cnt_zero       = (cnt_ff == '0);

   // result channel, fields from the lowest bit up
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_entry_ff.len, out_entry_ff.net[63:0], out_entry_ff.net[127:64]};
   assign rsp_tuser  = {out_status_ff, out_empty_ff, out_v6_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   // table fill never passes the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CW'(TABLE_DEPTH)) && (wcnt_ff <= CW'(TABLE_DEPTH)))
      else $error("table count beyond depth");

   // a result is only loaded when the output register can take it
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel != cpss_pkg::OUT_NONE) |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten");

   // a stalled result holds its last flag until taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_last_ff)))
      else $error("pending result changed");

   // a table rewrite never starts from the middle of a scan
   a_commit_end: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (ridx_ff == cnt_ff))
      else $error("table committed before scan end");
`endif

endmodule

/* tb/cidr_prefix_set_subtract_checker.sv */
// prefix set predictor and response checker for the cidr prefix set testbench
`timescale 1ns / 1ps
module cidr_prefix_set_subtract_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // network_high, network_low, prefix_bits
   input  logic [cpss_pkg::DATA_BITS-1:0]     req_tdata,
   // operation, family_v6
   input  logic [cpss_pkg::IN_USER_BITS-1:0]  req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_network_high, out_network_low, out_prefix_bits
   input  logic [cpss_pkg::DATA_BITS-1:0]     rsp_tdata,
   // out_family_v6, table_empty, status
   input  logic [cpss_pkg::OUT_USER_BITS-1:0] rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked
);

   typedef struct {
      logic [127:0] net;
      int unsigned  len;
   } prefix_rec;

   typedef struct {
      logic [127:0]         net;
      logic [7:0]           len;
      bit                   fam_v6;
      bit                   empty;
      cpss_pkg::status_type st;
      bit                   last;
   } rsp_rec;

   prefix_rec         prefix_table[$];
   cpss_pkg::fam_type run_family;
   bit                overflow_flag;
   rsp_rec            expected_rsps[$];

   function automatic logic [127:0] len_mask(int unsigned len);
      if (len == 0) return '0;
      return ~({128{1'b1}} >> len);
   endfunction

   function automatic bit contains(prefix_rec a, prefix_rec b);
      return (a.len <= b.len) && ((b.net & len_mask(a.len)) == a.net);
   endfunction

   function automatic bit are_siblings(prefix_rec a, prefix_rec b);
      if (a.len != b.len || a.len == 0 || a.net == b.net) return 0;
      return (a.net & len_mask(a.len - 1)) == (b.net & len_mask(b.len - 1));
   endfunction

   function automatic bit sorts_first(prefix_rec a, prefix_rec b);
      return {a.net, 8'(a.len)} < {b.net, 8'(b.len)};
   endfunction

   // reduce to the minimal form: drop contained entries, merge siblings
   task automatic reduce_set(ref prefix_rec w[$]);
      bit changed;
      int i, j;
      changed = 1;
      while (changed) begin
         changed = 0;
         for (i = 0; i < w.size() && !changed; i++) begin
            for (j = 0; j < w.size() && !changed; j++) begin
               if (i == j) continue;
               if (contains(w[i], w[j])) begin
                  w[j] = w[w.size() - 1];
                  void'(w.pop_back());
                  changed = 1;
               end else if (are_siblings(w[i], w[j])) begin
                  w[i].len = w[i].len - 1;
                  w[i].net = w[i].net & len_mask(w[i].len);
                  w[j] = w[w.size() - 1];
                  void'(w.pop_back());
                  changed = 1;
               end
            end
         end
      end
   endtask

   task automatic sort_set(ref prefix_rec w[$]);
      prefix_rec t;
      int i, j;
      for (i = 1; i < w.size(); i++) begin
         t = w[i];
         j = i - 1;
         while (j >= 0 && sorts_first(t, w[j])) begin
            w[j + 1] = w[j];
            j--;
         end
         w[j + 1] = t;
      end
   endtask

   task automatic push_rsp(logic [127:0] net, int unsigned len, bit empty,
                           cpss_pkg::status_type st, bit last);
      rsp_rec r;
      r.net    = net;
      r.len    = 8'(len);
      r.fam_v6 = (run_family == cpss_pkg::FAM_V6);
      r.empty  = empty;
      r.st     = st;
      r.last   = last;
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // work out the responses of one request transaction
   task automatic predict_request(logic [cpss_pkg::DATA_BITS-1:0] data,
                                  logic [cpss_pkg::IN_USER_BITS-1:0] user);
      cpss_pkg::op_type     op;
      bit                   v6;
      int unsigned          len, n, i, l;
      cpss_pkg::fam_type    fam;
      prefix_rec            x, s;
      prefix_rec            work[$];
      cpss_pkg::status_type st;
      op  = cpss_pkg::op_type'(user[1:0]);
      v6  = user[2];
      len = 32'(data[135:128]);
      fam = v6 ? cpss_pkg::FAM_V6 : cpss_pkg::FAM_V4;
      if (op == cpss_pkg::OP_RESERVED) return;
      if (op == cpss_pkg::OP_FINISH) begin
         st = overflow_flag ? cpss_pkg::ST_OVERFLOW : cpss_pkg::ST_OK;
         n  = prefix_table.size();
         if (n > cpss_pkg::RESULT_LIMIT) n = cpss_pkg::RESULT_LIMIT;
         if (n == 0) push_rsp('0, 0, 1, st, 1);
         for (i = 0; i < n; i++)
            push_rsp(prefix_table[i].net, prefix_table[i].len, 0, st, i == n - 1);
         prefix_table.delete();
         run_family    = cpss_pkg::FAM_NONE;
         overflow_flag = 0;
         return;
      end
      if (len > 128) len = 128;
      if (!v6 && len < 96) begin
         push_rsp('0, 0, prefix_table.size() == 0, cpss_pkg::ST_BAD_V4, 1);
         return;
      end
      if (run_family != cpss_pkg::FAM_NONE && run_family != fam) begin
         push_rsp('0, 0, prefix_table.size() == 0, cpss_pkg::ST_FAMILY, 1);
         return;
      end
      run_family = fam;
      x.len = len;
      x.net = v6 ? {data[63:0], data[127:64]} : {96'b0, data[95:64]};
      x.net = x.net & len_mask(len);
      if (op == cpss_pkg::OP_INCLUDE) begin
         work = prefix_table;
         work.insert(work.size(), x);
      end else begin
         foreach (prefix_table[k]) begin
            if (contains(x, prefix_table[k])) continue;
            if (contains(prefix_table[k], x)) begin
               // split the covering entry down the path to the excluded range
               for (l = prefix_table[k].len + 1; l <= x.len; l++) begin
                  s.len = l;
                  s.net = (x.net & len_mask(l)) ^ (128'b1 << (128 - l));
                  work.insert(work.size(), s);
               end
            end else begin
               work.insert(work.size(), prefix_table[k]);
            end
         end
      end
      reduce_set(work);
      sort_set(work);
      if (work.size() > cpss_pkg::TABLE_DEPTH_DEF) begin
         work = work[0:cpss_pkg::TABLE_DEPTH_DEF-1];
         overflow_flag = 1;
      end
      prefix_table = work;
      push_rsp('0, 0, work.size() == 0,
               overflow_flag ? cpss_pkg::ST_OVERFLOW : cpss_pkg::ST_OK, 1);
   endtask

   // compare accepted responses, then predict accepted requests
   always @(posedge clock) begin
      rsp_rec e;
      logic [127:0] a_net;
      bit bad;
      if (reset) begin
         prefix_table.delete();
         expected_rsps.delete();
         run_family    = cpss_pkg::FAM_NONE;
         overflow_flag = 0;
         fail_count    = 0;
         checked       = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            a_net = {rsp_tdata[63:0], rsp_tdata[127:64]};
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected response net %h len %0d", $realtime,
                           a_net, rsp_tdata[135:128]);
            end else begin
               e = expected_rsps.pop_front();
               checked++;
               bad = (a_net != e.net) || (rsp_tdata[135:128] != e.len) ||
                     (rsp_tuser[0] != e.fam_v6) || (rsp_tuser[1] != e.empty) ||
                     (rsp_tuser[3:2] != e.st) || (rsp_tlast != e.last);
               if (bad) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t mismatch exp net %h len %0d v6 %0d empty %0d st %0d last %0d",
                              $realtime, e.net, e.len, e.fam_v6, e.empty, e.st, e.last);
                     $display("%0t          got net %h len %0d v6 %0d empty %0d st %0d last %0d",
                              $realtime, a_net, rsp_tdata[135:128], rsp_tuser[0],
                              rsp_tuser[1], rsp_tuser[3:2], rsp_tlast);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) predict_request(req_tdata, req_tuser);
      end
      pending = expected_rsps.size();
   end

endmodule

/* tb/testbench.sv */
// stimulus, flow control and verdict for the cidr prefix set block
`timescale 1ns / 1ps
module testbench;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 3000;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [cpss_pkg::DATA_BITS-1:0]     req_tdata;
   logic [cpss_pkg::IN_USER_BITS-1:0]  req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [cpss_pkg::DATA_BITS-1:0]     rsp_tdata;
   logic [cpss_pkg::OUT_USER_BITS-1:0] rsp_tuser;
   logic                               rsp_tlast;
   int                                 fail_count, pending, checked;

   int  phase;
   bit  hold_go, hold_done;
   int  cycles;
   int  n_include, n_exclude, n_finish, n_noise;

   cidr_prefix_set_subtract_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   cidr_prefix_set_subtract_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic bit roll_idle(bit sender);
      int p;
      case (phase)
         1:       p = sender ? 51 : 0;
         2:       p = sender ? 0 : 51;
         3:       p = 17;
         default: p = 0;
      endcase
      return $urandom_range(99) < p;
   endfunction

   // response side flow control, with one long hold-off
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_tready <= 0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1;
         end else begin
            rsp_tready <= !roll_idle(0);
         end
      end
   end

   // offer one request transaction and wait for its acceptance
   task automatic send_request(cpss_pkg::op_type op, logic [63:0] hi, logic [63:0] lo,
                               logic [7:0] len, bit v6);
      while (roll_idle(1)) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {len, lo, hi};
      req_tuser  <= {v6, op};
      do @(posedge clock); while (!req_tready);
      case (op)
         cpss_pkg::OP_INCLUDE: n_include++;
         cpss_pkg::OP_EXCLUDE: n_exclude++;
         cpss_pkg::OP_FINISH:  n_finish++;
         default:              n_noise++;
      endcase
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // stimulus
   initial begin
      logic [127:0]     base, net;
      logic [7:0]       len;
      bit               v6, wrong;
      int               sent, target, in_run, k;
      cpss_pkg::op_type op;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = '0;
      reset      = 1;
      phase      = 0;
      hold_go    = 0;
      hold_done  = 0;
      n_include = 0; n_exclude = 0; n_finish = 0; n_noise = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty finish, overflow by a deep split, rejects, merges
      send_request(cpss_pkg::OP_FINISH, '0, '0, 8'd0, 0);
      send_request(cpss_pkg::OP_INCLUDE, '1, '1, 8'd0, 1);
      send_request(cpss_pkg::OP_EXCLUDE, '1, '1, 8'd128, 1);
      send_request(cpss_pkg::OP_INCLUDE, '0, '0, 8'd128, 1);
      send_request(cpss_pkg::OP_FINISH, '1, '1, 8'd255, 1);
      send_request(cpss_pkg::OP_INCLUDE, '1, '1, 8'd255, 0);
      send_request(cpss_pkg::OP_INCLUDE, '0, '0, 8'd95, 0);
      send_request(cpss_pkg::OP_INCLUDE, '0, '0, 8'd64, 1);
      send_request(cpss_pkg::OP_INCLUDE, '0, 64'hffff_fffe, 8'd128, 0);
      send_request(cpss_pkg::OP_EXCLUDE, '0, 64'h0a00_0000, 8'd104, 0);
      send_request(cpss_pkg::OP_INCLUDE, '1, '0, 8'd96, 0);
      send_request(cpss_pkg::OP_EXCLUDE, '0, 64'h0a00_0000, 8'd104, 0);
      send_request(cpss_pkg::OP_EXCLUDE, '0, '0, 8'd96, 0);
      send_request(cpss_pkg::OP_RESERVED, '1, '1, 8'd7, 1);
      send_request(cpss_pkg::OP_FINISH, '0, '0, 8'd0, 0);
      send_request(cpss_pkg::OP_EXCLUDE, 64'h2001_0db8_0000_0000, '0, 8'd32, 1);
      send_request(cpss_pkg::OP_INCLUDE, '0, '0, 8'd100, 0);
      send_request(cpss_pkg::OP_INCLUDE, '0, '0, 8'd128, 1);
      send_request(cpss_pkg::OP_INCLUDE, '0, '0, 8'd1, 1);
      send_request(cpss_pkg::OP_INCLUDE, 64'h8000_0000_0000_0000, '0, 8'd1, 1);
      send_request(cpss_pkg::OP_FINISH, '0, '0, 8'd0, 1);

      // random runs around a shared base so entries overlap and merge
      sent = 0;
      while (sent < 420) begin
         v6     = 1'($urandom_range(1));
         base   = {rand64(), rand64()};
         target = $urandom_range(28, 3);
         in_run = 0;
         while (in_run < target && sent < 420) begin
            phase = (sent * 4) / 420;
            if (phase == 0 && sent == 30) hold_go = 1;
            k = $urandom_range(99);
            wrong = 0;
            op = (k < 60) ? cpss_pkg::OP_INCLUDE : cpss_pkg::OP_EXCLUDE;
            if (v6) len = (k % 5 == 0) ? 8'($urandom_range(8)) : 8'($urandom_range(128));
            else    len = 8'($urandom_range(128, 96));
            net = base ^ ({rand64(), rand64()} >> $urandom_range(127));
            if (!v6) net[127:32] = {rand64(), $urandom};
            // noise: foreign family, short ipv4, oversized length, stray op, any address
            if (k >= 90) begin
               case (k % 5)
                  0: wrong = 1;
                  1: begin len = 8'($urandom_range(95)); end
                  2: len = 8'($urandom_range(255, 129));
                  3: op = cpss_pkg::OP_RESERVED;
                  default: net = {rand64(), rand64()};
               endcase
            end
            if (!v6 && k % 5 == 1 && k >= 90) send_request(op, net[63:0], net[127:64], len, 0);
            else send_request(op, net[127:64], net[63:0], len, v6 ^ wrong);
            if (op != cpss_pkg::OP_RESERVED) begin
               sent++;
               in_run++;
            end
         end
         send_request(cpss_pkg::OP_FINISH, rand64(), rand64(), 8'($urandom),
                      1'($urandom_range(1)));
         sent++;
      end
      req_tvalid <= 0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d include, %0d exclude, %0d finish, %0d stray op transactions",
               n_include, n_exclude, n_finish, n_noise);
      $display("%0d response transactions checked over four flow control phases", checked);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
